// ===== rtl/core/cbeq_pkg.sv =====
// ----------------------------------------------------------------------------
// cbeq_pkg
// Shared types, constants and the control store of the biquad equalizer.
// ----------------------------------------------------------------------------
package cbeq_pkg;

    // Sizes
    localparam int BANDS        = 5;
    localparam int SAMPLE_BITS  = 24;
    localparam int COEFS        = 5;
    localparam int HIST_W       = 32;
    localparam int COEF_W       = 32;
    localparam int VOL_W        = 16;
    localparam int COEF_FRAC    = 28;
    localparam int VOL_FRAC     = 14;
    localparam int BAND_W       = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int OP_A_W       = COEF_W + 1;
    localparam int PROD_W       = OP_A_W + HIST_W;
    localparam int ACC_W        = PROD_W + 2;

    // Stream word layout
    localparam int IN_FIELDS_W  = SAMPLE_BITS + 3 + 3 + COEF_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int BAND_LSB     = SAMPLE_BITS;
    localparam int IDX_LSB      = SAMPLE_BITS + 3;
    localparam int COEF_LSB     = SAMPLE_BITS + 6;

    localparam logic [VOL_W-1:0]         VOL_RESET = VOL_W'(16384);
    localparam logic signed [COEF_W-1:0] COEF_ONE  = COEF_W'(1) << COEF_FRAC;
    localparam logic signed [ACC_W-1:0]  BAND_HALF = ACC_W'(1) << (COEF_FRAC - 1);
    localparam logic signed [ACC_W-1:0]  VOL_HALF  = ACC_W'(1) << (VOL_FRAC - 1);

    // Sequencer
    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] PC_WAIT = 4'd0;
    localparam logic [PC_W-1:0] PC_BAND = 4'd1;
    localparam logic [PC_W-1:0] PC_WB   = 4'd7;
    localparam logic [PC_W-1:0] PC_VOL  = 4'd8;
    localparam logic [PC_W-1:0] PC_OUT  = 4'd10;

    typedef enum logic [2:0] {
        MUL_B0X,
        MUL_B1X1,
        MUL_B2X2,
        MUL_A1Y1,
        MUL_A2Y2,
        MUL_VOL
    } t_mul_src;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } t_acc_op;

    typedef enum logic [1:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_WAIT,
        COND_MORE_BANDS
    } t_cond;

    typedef struct packed {
        logic            mul_en;
        t_mul_src        mul_src;
        logic            mul_neg;
        t_acc_op         acc_op;
        logic            wb_band;
        logic            wb_out;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_ucode;

    typedef struct packed {
        logic    mul_en;
        logic    neg;
        t_acc_op acc_op;
    } t_mac_ctrl;

    // Control store: one word per step
    function automatic t_ucode ucode_rom(input logic [PC_W-1:0] pc);
        t_ucode w;
        case (pc)
            4'd0:    w = '{1'b0, MUL_B0X,  1'b0, ACC_HOLD, 1'b0, 1'b0, COND_WAIT,  PC_WAIT};
            4'd1:    w = '{1'b1, MUL_B0X,  1'b0, ACC_HOLD, 1'b0, 1'b0, COND_NEXT,  PC_WAIT};
            4'd2:    w = '{1'b1, MUL_B1X1, 1'b0, ACC_LOAD, 1'b0, 1'b0, COND_NEXT,  PC_WAIT};
            4'd3:    w = '{1'b1, MUL_B2X2, 1'b0, ACC_ADD,  1'b0, 1'b0, COND_NEXT,  PC_WAIT};
            4'd4:    w = '{1'b1, MUL_A1Y1, 1'b1, ACC_ADD,  1'b0, 1'b0, COND_NEXT,  PC_WAIT};
            4'd5:    w = '{1'b1, MUL_A2Y2, 1'b1, ACC_ADD,  1'b0, 1'b0, COND_NEXT,  PC_WAIT};
            4'd6:    w = '{1'b0, MUL_B0X,  1'b0, ACC_ADD,  1'b0, 1'b0, COND_NEXT,  PC_WAIT};
            4'd7:    w = '{1'b0, MUL_B0X,  1'b0, ACC_HOLD, 1'b1, 1'b0, COND_MORE_BANDS,
                           PC_BAND};
            4'd8:    w = '{1'b1, MUL_VOL,  1'b0, ACC_HOLD, 1'b0, 1'b0, COND_NEXT,  PC_WAIT};
            4'd9:    w = '{1'b0, MUL_B0X,  1'b0, ACC_LOAD, 1'b0, 1'b0, COND_NEXT,  PC_WAIT};
            4'd10:   w = '{1'b0, MUL_B0X,  1'b0, ACC_HOLD, 1'b0, 1'b1, COND_ALWAYS, PC_WAIT};
            default: w = '{1'b0, MUL_B0X,  1'b0, ACC_HOLD, 1'b0, 1'b0, COND_ALWAYS, PC_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/cbeq_mac.sv =====
// ----------------------------------------------------------------------------
// cbeq_mac
// Registered multiplier, wide accumulator and the two rounding/clamp outputs.
// ----------------------------------------------------------------------------
module cbeq_mac (
    input  logic                                        i_clk,
    input  cbeq_pkg::t_mac_ctrl                         i_ctrl,
    input  logic signed [cbeq_pkg::OP_A_W-1:0]          i_op_a,
    input  logic signed [cbeq_pkg::HIST_W-1:0]          i_op_b,
    output logic signed [cbeq_pkg::HIST_W-1:0]          o_band_y,
    output logic signed [cbeq_pkg::SAMPLE_BITS-1:0]     o_vol_y
);

    localparam int BSH_W = cbeq_pkg::ACC_W - cbeq_pkg::COEF_FRAC;
    localparam int VSH_W = cbeq_pkg::ACC_W - cbeq_pkg::VOL_FRAC;
    localparam int SB    = cbeq_pkg::SAMPLE_BITS;
    localparam int HW    = cbeq_pkg::HIST_W;

    logic signed [cbeq_pkg::PROD_W-1:0] r_prod;
    logic                               r_neg;
    logic signed [cbeq_pkg::ACC_W-1:0]  r_acc;
    logic signed [cbeq_pkg::ACC_W-1:0]  s_term;
    logic signed [cbeq_pkg::ACC_W-1:0]  s_band_sum;
    logic signed [cbeq_pkg::ACC_W-1:0]  s_vol_sum;
    logic        [BSH_W-1:0]            s_band_sh;
    logic        [VSH_W-1:0]            s_vol_sh;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= i_op_a * i_op_b;
            r_neg  <= i_ctrl.neg;
        end
    end

    assign s_term = r_neg ? -cbeq_pkg::ACC_W'(r_prod) : cbeq_pkg::ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        case (i_ctrl.acc_op)
            cbeq_pkg::ACC_LOAD: r_acc <= s_term;
            cbeq_pkg::ACC_ADD:  r_acc <= r_acc + s_term;
            default:            r_acc <= r_acc;
        endcase
    end

    // Round half up, then saturate
    assign s_band_sum = r_acc + cbeq_pkg::BAND_HALF;
    assign s_band_sh  = s_band_sum[cbeq_pkg::ACC_W-1:cbeq_pkg::COEF_FRAC];
    assign s_vol_sum  = r_acc + cbeq_pkg::VOL_HALF;
    assign s_vol_sh   = s_vol_sum[cbeq_pkg::ACC_W-1:cbeq_pkg::VOL_FRAC];

    always_comb begin
        if ((&s_band_sh[BSH_W-1:HW-1]) || !(|s_band_sh[BSH_W-1:HW-1])) begin
            o_band_y = s_band_sh[HW-1:0];
        end else if (s_band_sh[BSH_W-1]) begin
            o_band_y = {1'b1, {(HW-1){1'b0}}};
        end else begin
            o_band_y = {1'b0, {(HW-1){1'b1}}};
        end
    end

    always_comb begin
        if ((&s_vol_sh[VSH_W-1:SB-1]) || !(|s_vol_sh[VSH_W-1:SB-1])) begin
            o_vol_y = s_vol_sh[SB-1:0];
        end else if (s_vol_sh[VSH_W-1]) begin
            o_vol_y = {1'b1, {(SB-1){1'b0}}};
        end else begin
            o_vol_y = {1'b0, {(SB-1){1'b1}}};
        end
    end

endmodule

// ===== rtl/core/cascaded_biquad_equalizer_top.sv =====
// ----------------------------------------------------------------------------
// cascaded_biquad_equalizer_top
// Five-band direct-form-I biquad cascade with output volume, one shared MAC.
// ----------------------------------------------------------------------------
// A filter word (tuser = 0) carries one Q1.23 sample that runs through five
// cascaded biquads and an unsigned Q2.14 volume stage; it returns one clamped
// Q1.23 sample on the master side. A coefficient word (tuser = 1) stores one
// Q4.28 coefficient (b0, b1, b2, a1, a2) for one band, returns nothing, and
// leaves the sequencer at its wait step; a band or slot out of range is
// dropped. All arithmetic goes through one 33x32 multiplier and a 67-bit
// accumulator driven by an 11-step control store: each band takes 7 steps
// (5 products, one drain, one round-and-writeback), the volume stage 3. The
// next word is accepted as soon as the sequencer is back at its wait step,
// even while the finished sample still sits in the output register. The
// finish step holds only while that register is full and i_m_tready is low.
// The user must write volume through the configuration port while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module cascaded_biquad_equalizer_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // slave side
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // sample_in [23:0], band [26:24], coef_index [29:27], coef_value [61:30]
    input  logic [cbeq_pkg::IN_TDATA_W-1:0]        i_s_tdata,
    // mode [0]
    input  logic [0:0]                             i_s_tuser,
    // master side
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // sample_out [23:0]
    output logic [cbeq_pkg::OUT_TDATA_W-1:0]       o_m_tdata,
    // volume register
    input  logic                                   i_cfg_wr_en,
    input  logic [cbeq_pkg::VOL_W-1:0]             i_cfg_wr_data
);

    localparam int SB = cbeq_pkg::SAMPLE_BITS;
    localparam int HW = cbeq_pkg::HIST_W;
    localparam logic [cbeq_pkg::BAND_W-1:0] LAST_BAND =
        cbeq_pkg::BAND_W'(cbeq_pkg::BANDS - 1);

    // Input word fields
    logic                               s_mode;
    logic signed [SB-1:0]               s_sample;
    logic        [2:0]                  s_band;
    logic        [2:0]                  s_idx;
    logic signed [cbeq_pkg::COEF_W-1:0] s_coef;
    logic                               s_accept;
    logic                               s_start;

    assign s_mode   = i_s_tuser[0];
    assign s_sample = i_s_tdata[SB-1:0];
    assign s_band   = i_s_tdata[cbeq_pkg::BAND_LSB+2:cbeq_pkg::BAND_LSB];
    assign s_idx    = i_s_tdata[cbeq_pkg::IDX_LSB+2:cbeq_pkg::IDX_LSB];
    assign s_coef   = i_s_tdata[cbeq_pkg::COEF_LSB+cbeq_pkg::COEF_W-1:cbeq_pkg::COEF_LSB];

    // State
    logic        [cbeq_pkg::PC_W-1:0]   r_pc;
    logic        [cbeq_pkg::PC_W-1:0]   n_pc;
    logic        [cbeq_pkg::BAND_W-1:0] r_band;
    logic signed [HW-1:0]               r_x;
    logic        [cbeq_pkg::VOL_W-1:0]  r_vol;
    logic signed [cbeq_pkg::COEF_W-1:0] r_coef [cbeq_pkg::BANDS][cbeq_pkg::COEFS];
    logic signed [HW-1:0]               r_x1 [cbeq_pkg::BANDS];
    logic signed [HW-1:0]               r_x2 [cbeq_pkg::BANDS];
    logic signed [HW-1:0]               r_y1 [cbeq_pkg::BANDS];
    logic signed [HW-1:0]               r_y2 [cbeq_pkg::BANDS];
    logic                               r_out_valid;
    logic        [cbeq_pkg::OUT_TDATA_W-1:0] r_out_data;

    cbeq_pkg::t_ucode                   s_word;
    cbeq_pkg::t_mac_ctrl                s_mac_ctrl;
    logic                               s_stall;
    logic signed [cbeq_pkg::OP_A_W-1:0] s_op_a;
    logic signed [HW-1:0]               s_op_b;
    logic signed [HW-1:0]               s_band_y;
    logic signed [SB-1:0]               s_vol_y;

    assign o_s_tready = (r_pc == cbeq_pkg::PC_WAIT);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign s_start    = s_accept && !s_mode;

    // Fetch the control word for this step
    assign s_word  = cbeq_pkg::ucode_rom(r_pc);
    // Hold the finish step while the previous result is still unclaimed
    assign s_stall = s_word.wb_out && r_out_valid && !i_m_tready;

    // Step counter and jumps
    always_comb begin
        n_pc = r_pc + cbeq_pkg::PC_W'(1);
        case (s_word.cond)
            cbeq_pkg::COND_NEXT:       n_pc = r_pc + cbeq_pkg::PC_W'(1);
            cbeq_pkg::COND_ALWAYS:     n_pc = s_word.target;
            cbeq_pkg::COND_WAIT: begin
                if (!s_start) n_pc = s_word.target;
            end
            cbeq_pkg::COND_MORE_BANDS: begin
                if (r_band != LAST_BAND) n_pc = s_word.target;
            end
            default:                   n_pc = cbeq_pkg::PC_WAIT;
        endcase
        if (s_stall) n_pc = r_pc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= cbeq_pkg::PC_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    // Operand select for the shared multiplier
    always_comb begin
        s_op_a = cbeq_pkg::OP_A_W'(r_coef[r_band][0]);
        s_op_b = r_x;
        case (s_word.mul_src)
            cbeq_pkg::MUL_B0X: begin
                s_op_a = cbeq_pkg::OP_A_W'(r_coef[r_band][0]);
                s_op_b = r_x;
            end
            cbeq_pkg::MUL_B1X1: begin
                s_op_a = cbeq_pkg::OP_A_W'(r_coef[r_band][1]);
                s_op_b = r_x1[r_band];
            end
            cbeq_pkg::MUL_B2X2: begin
                s_op_a = cbeq_pkg::OP_A_W'(r_coef[r_band][2]);
                s_op_b = r_x2[r_band];
            end
            cbeq_pkg::MUL_A1Y1: begin
                s_op_a = cbeq_pkg::OP_A_W'(r_coef[r_band][3]);
                s_op_b = r_y1[r_band];
            end
            cbeq_pkg::MUL_A2Y2: begin
                s_op_a = cbeq_pkg::OP_A_W'(r_coef[r_band][4]);
                s_op_b = r_y2[r_band];
            end
            cbeq_pkg::MUL_VOL: begin
                // unsigned gain: zero-extend
                s_op_a = $signed(cbeq_pkg::OP_A_W'(r_vol));
                s_op_b = r_x;
            end
            default: begin
                s_op_a = cbeq_pkg::OP_A_W'(r_coef[r_band][0]);
                s_op_b = r_x;
            end
        endcase
    end

    assign s_mac_ctrl.mul_en = s_word.mul_en;
    assign s_mac_ctrl.neg    = s_word.mul_neg;
    assign s_mac_ctrl.acc_op = s_word.acc_op;

    cbeq_mac u_mac (
        .i_clk    (i_clk),
        .i_ctrl   (s_mac_ctrl),
        .i_op_a   (s_op_a),
        .i_op_b   (s_op_b),
        .o_band_y (s_band_y),
        .o_vol_y  (s_vol_y)
    );

    // Running sample and band counter: load on a filter word, advance per band
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band <= '0;
        end else if (s_word.wb_band) begin
            r_band <= (r_band == LAST_BAND) ? '0 : r_band + cbeq_pkg::BAND_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_start) begin
            r_x <= HW'(s_sample);
        end else if (s_word.wb_band) begin
            r_x <= s_band_y;
        end
    end

    // Volume register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol <= cbeq_pkg::VOL_RESET;
        end else if (i_cfg_wr_en) begin
            r_vol <= i_cfg_wr_data;
        end
    end

    // Coefficient table: drop writes outside the band/slot range
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < cbeq_pkg::BANDS; b++) begin
                for (int k = 0; k < cbeq_pkg::COEFS; k++) begin
                    r_coef[b][k] <= (k == 0) ? cbeq_pkg::COEF_ONE : '0;
                end
            end
        end else if (s_accept && s_mode) begin
            for (int b = 0; b < cbeq_pkg::BANDS; b++) begin
                for (int k = 0; k < cbeq_pkg::COEFS; k++) begin
                    if ((s_band == 3'(b)) && (s_idx == 3'(k))) begin
                        r_coef[b][k] <= s_coef;
                    end
                end
            end
        end
    end

    // Band history: shift in the band's input and rounded output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < cbeq_pkg::BANDS; b++) begin
                r_x1[b] <= '0;
                r_x2[b] <= '0;
                r_y1[b] <= '0;
                r_y2[b] <= '0;
            end
        end else if (s_word.wb_band) begin
            r_x2[r_band] <= r_x1[r_band];
            r_x1[r_band] <= r_x;
            r_y2[r_band] <= r_y1[r_band];
            r_y1[r_band] <= s_band_y;
        end
    end

    // Output register: parts the sequencer from the master side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_word.wb_out && !s_stall) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_word.wb_out && !s_stall) begin
            r_out_data <= cbeq_pkg::OUT_TDATA_W'($unsigned(s_vol_y));
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // Checks
    a_band_zero_at_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == cbeq_pkg::PC_WAIT) |-> (r_band == '0))
        else $error("band counter not cleared at wait step");

    a_coef_write_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && s_mode) |=> (r_pc == cbeq_pkg::PC_WAIT))
        else $error("coefficient word started the sequencer");

    a_finish_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_pc == cbeq_pkg::PC_OUT) && r_out_valid && !i_m_tready)
        |=> ((r_pc == cbeq_pkg::PC_OUT) && r_out_valid))
        else $error("finish step left while result unclaimed");

    a_band_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_word.wb_band && (r_band == LAST_BAND)) |=> (r_pc == cbeq_pkg::PC_VOL))
        else $error("last band did not go on to the volume stage");

endmodule
